// ===== src/svb_pkg.sv =====
`timescale 1ns / 1ps

package svb_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int STEP_W      = 4;
	localparam logic [STEP_W-1:0] LAST_STEP = 4'd12;

	typedef struct packed {
		logic [16:0]        weight;
		logic signed [31:0] bind_x;
		logic signed [31:0] bind_y;
		logic signed [23:0] bone_xx;
		logic signed [23:0] bone_xy;
		logic signed [23:0] bone_yx;
		logic signed [23:0] bone_yy;
		logic signed [31:0] bone_tx;
		logic signed [31:0] bone_ty;
		logic               last_influence;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
	} out_item_t;

	typedef enum logic [2:0] {
		R_INV_XX = 3'd0,
		R_INV_XY = 3'd1,
		R_INV_YX = 3'd2,
		R_INV_YY = 3'd3,
		R_INV_TX = 3'd4,
		R_INV_TY = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;

	typedef enum logic [3:0] {
		A_BXX, A_BXY, A_BYX, A_BYY, A_IXX, A_IXY, A_IYX, A_IYY, A_W
	} a_sel_t;

	typedef enum logic [2:0] {B_BX, B_BY, B_MX, B_MY, B_PX, B_PY} b_sel_t;

	typedef enum logic [1:0] {K_NONE, K_FIRST, K_SECOND, K_SINGLE} kind_t;

	typedef enum logic [2:0] {D_NONE, D_MX, D_MY, D_PX, D_PY, D_AX, D_AY} dst_t;

	typedef struct packed {
		a_sel_t a_sel;
		b_sel_t b_sel;
		kind_t  kind;
		logic   slot;
		dst_t   dst;
	} step_ctrl_t;

	localparam step_ctrl_t CTRL_NOP = '{a_sel: A_W, b_sel: B_BX, kind: K_NONE,
		slot: 1'b0, dst: D_NONE};

	// product schedule; step 8 idles until px lands
	function automatic step_ctrl_t step_ctrl(input logic [STEP_W-1:0] s);
		step_ctrl_t c;
		c = CTRL_NOP;
		unique case (s)
			4'd0:    c = '{A_BXX, B_BX, K_FIRST,  1'b0, D_NONE};
			4'd1:    c = '{A_BYX, B_BY, K_SECOND, 1'b0, D_MX};
			4'd2:    c = '{A_BXY, B_BX, K_FIRST,  1'b1, D_NONE};
			4'd3:    c = '{A_BYY, B_BY, K_SECOND, 1'b1, D_MY};
			4'd4:    c = '{A_IXX, B_MX, K_FIRST,  1'b0, D_NONE};
			4'd5:    c = '{A_IXY, B_MX, K_FIRST,  1'b1, D_NONE};
			4'd6:    c = '{A_IYX, B_MY, K_SECOND, 1'b0, D_PX};
			4'd7:    c = '{A_IYY, B_MY, K_SECOND, 1'b1, D_PY};
			4'd9:    c = '{A_W,   B_PX, K_SINGLE, 1'b0, D_AX};
			4'd10:   c = '{A_W,   B_PY, K_SINGLE, 1'b0, D_AY};
			default: c = CTRL_NOP;
		endcase
		return c;
	endfunction

	localparam logic signed [59:0] S32_MAX = 60'sd2147483647;
	localparam logic signed [59:0] S32_MIN = -60'sd2147483648;
	localparam logic signed [59:0] S48_MAX = 60'sd140737488355327;
	localparam logic signed [59:0] S48_MIN = -60'sd140737488355328;

	function automatic logic signed [31:0] sat32(input logic signed [59:0] v);
		logic signed [59:0] r;
		r = v;
		if (v > S32_MAX) r = S32_MAX;
		else if (v < S32_MIN) r = S32_MIN;
		return r[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [59:0] v);
		logic signed [59:0] r;
		r = v;
		if (v > S48_MAX) r = S48_MAX;
		else if (v < S48_MIN) r = S48_MIN;
		return r[47:0];
	endfunction

endpackage

// ===== src/svb_chan_if.sv =====
`timescale 1ns / 1ps

interface svb_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== src/svb_mul.sv =====
`timescale 1ns / 1ps

module svb_mul (
	input  logic               clk,
	input  logic signed [24:0] a,
	input  logic signed [31:0] b,
	output logic signed [56:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= 57'(a) * 57'(b);
	end

endmodule

// ===== src/svb_seq.sv =====
`timescale 1ns / 1ps

module svb_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_stall,
	output logic                ready,
	output logic                out_load,
	output svb_pkg::step_ctrl_t ctrl
);

	svb_pkg::state_t state_q, state_d;
	logic [svb_pkg::STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svb_pkg::S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		ready    = 1'b0;
		out_load = 1'b0;
		ctrl     = svb_pkg::CTRL_NOP;
		unique case (state_q)
			svb_pkg::S_IDLE: begin
				ready = 1'b1;
				if (in_fire) begin
					state_d = svb_pkg::S_RUN;
					step_d  = '0;
				end
			end
			svb_pkg::S_RUN: begin
				ctrl = svb_pkg::step_ctrl(step_q);
				if (step_q == svb_pkg::LAST_STEP) state_d = svb_pkg::S_OUT;
				else step_d = step_q + 1'b1;
			end
			svb_pkg::S_OUT: begin
				if (!out_stall) begin
					out_load = 1'b1;
					state_d  = svb_pkg::S_IDLE;
				end
			end
			default: state_d = svb_pkg::S_IDLE;
		endcase
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == svb_pkg::S_RUN |-> step_q <= svb_pkg::LAST_STEP)
		else $error("step counter past schedule");

	a_idle_nop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != svb_pkg::S_RUN |-> ctrl.kind == svb_pkg::K_NONE)
		else $error("product issued outside run");

endmodule

// ===== src/skinned_vertex_blend_2d_core.sv =====
`timescale 1ns / 1ps
// channel    dir  payload                               beat when
// influence  in   weight, bind_x/y, bone matrix, last   valid && ready
// vertex     out  vertex_x, vertex_y                    valid && ready
// wr_*       in   wr_idx, wr_data                       wr_en
//
// Per influence: 1 accept, 13 sequencer steps over the single
// 25x32 multiplier (10 products, one wait for px, two drain), 1 output step.
// Reset clears the accumulators and loads the identity inverse; no sweep.
// A result waits in the vertex register; the next influence is taken meanwhile
// and the output step of a last influence stalls while the previous result is unread.

module skinned_vertex_blend_2d_core #(
	parameter int FRAC_BITS = svb_pkg::FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_idx,
	input  logic [31:0] wr_data,
	svb_chan_if.sink    influence,
	svb_chan_if.source  vertex
);

	localparam logic signed [58:0] HALF_F = 59'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [58:0] HALF_W = 59'sd1 <<< (svb_pkg::WEIGHT_BITS - 1);

	logic signed [23:0] inv_xx_q, inv_xy_q, inv_yx_q, inv_yy_q;
	logic signed [31:0] inv_tx_q, inv_ty_q;

	svb_pkg::in_item_t   in_q;
	svb_pkg::step_ctrl_t ctrl, ctrl_s1;
	svb_pkg::dst_t       dst_s2;
	logic                ready, in_fire, out_load, out_stall, out_valid_q;
	logic signed [24:0]  op_a;
	logic signed [31:0]  op_b;
	logic signed [56:0]  prod_q;
	logic signed [56:0]  first_x_q, first_y_q;
	logic signed [58:0]  base, half, sum_s2, sh;
	logic signed [59:0]  addend, tot;
	logic signed [31:0]  mx_q, my_q, px_q, py_q;
	logic signed [47:0]  acc_x_q, acc_y_q;
	svb_pkg::out_item_t  out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_xx_q <= 24'sd65536;
			inv_xy_q <= '0;
			inv_yx_q <= '0;
			inv_yy_q <= 24'sd65536;
			inv_tx_q <= '0;
			inv_ty_q <= '0;
		end else if (wr_en) begin
			unique case (wr_idx)
				svb_pkg::R_INV_XX: inv_xx_q <= wr_data[23:0];
				svb_pkg::R_INV_XY: inv_xy_q <= wr_data[23:0];
				svb_pkg::R_INV_YX: inv_yx_q <= wr_data[23:0];
				svb_pkg::R_INV_YY: inv_yy_q <= wr_data[23:0];
				svb_pkg::R_INV_TX: inv_tx_q <= wr_data;
				svb_pkg::R_INV_TY: inv_ty_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign influence.ready = ready;
	assign in_fire   = influence.valid && ready;
	assign out_stall = in_q.last_influence && out_valid_q && !vertex.ready;

	always_ff @(posedge clk) begin
		if (in_fire) in_q <= influence.data;
	end

	svb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_stall(out_stall),
		.ready    (ready),
		.out_load (out_load),
		.ctrl     (ctrl)
	);

	always_comb begin
		unique case (ctrl.a_sel)
			svb_pkg::A_BXX: op_a = 25'(in_q.bone_xx);
			svb_pkg::A_BXY: op_a = 25'(in_q.bone_xy);
			svb_pkg::A_BYX: op_a = 25'(in_q.bone_yx);
			svb_pkg::A_BYY: op_a = 25'(in_q.bone_yy);
			svb_pkg::A_IXX: op_a = 25'(inv_xx_q);
			svb_pkg::A_IXY: op_a = 25'(inv_xy_q);
			svb_pkg::A_IYX: op_a = 25'(inv_yx_q);
			svb_pkg::A_IYY: op_a = 25'(inv_yy_q);
			svb_pkg::A_W:   op_a = $signed({8'b0, in_q.weight});
			default:        op_a = '0;
		endcase
		unique case (ctrl.b_sel)
			svb_pkg::B_BX: op_b = in_q.bind_x;
			svb_pkg::B_BY: op_b = in_q.bind_y;
			svb_pkg::B_MX: op_b = mx_q;
			svb_pkg::B_MY: op_b = my_q;
			svb_pkg::B_PX: op_b = px_q;
			svb_pkg::B_PY: op_b = py_q;
			default:       op_b = '0;
		endcase
	end

	svb_mul u_mul (
		.clk   (clk),
		.a     (op_a),
		.b     (op_b),
		.prod_q(prod_q)
	);

	// pair sum with rounding bias
	always_comb begin
		base = ctrl_s1.slot ? 59'(first_y_q) : 59'(first_x_q);
		if (ctrl_s1.kind == svb_pkg::K_SINGLE) begin
			base = '0;
			half = HALF_W;
		end else begin
			half = HALF_F;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= svb_pkg::CTRL_NOP;
			dst_s2  <= svb_pkg::D_NONE;
		end else begin
			ctrl_s1 <= ctrl;
			if (ctrl_s1.kind == svb_pkg::K_SECOND || ctrl_s1.kind == svb_pkg::K_SINGLE)
				dst_s2 <= ctrl_s1.dst;
			else
				dst_s2 <= svb_pkg::D_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.kind == svb_pkg::K_FIRST) begin
			if (ctrl_s1.slot) first_y_q <= prod_q;
			else first_x_q <= prod_q;
		end
		sum_s2 <= base + 59'(prod_q) + half;
	end

	// shift, translate or accumulate, saturate
	always_comb begin
		if (dst_s2 == svb_pkg::D_AX || dst_s2 == svb_pkg::D_AY)
			sh = sum_s2 >>> svb_pkg::WEIGHT_BITS;
		else
			sh = sum_s2 >>> FRAC_BITS;
		unique case (dst_s2)
			svb_pkg::D_MX: addend = 60'(in_q.bone_tx);
			svb_pkg::D_MY: addend = 60'(in_q.bone_ty);
			svb_pkg::D_PX: addend = 60'(inv_tx_q);
			svb_pkg::D_PY: addend = 60'(inv_ty_q);
			svb_pkg::D_AX: addend = 60'(acc_x_q);
			svb_pkg::D_AY: addend = 60'(acc_y_q);
			default:       addend = '0;
		endcase
		tot = 60'(sh) + addend;
	end

	always_ff @(posedge clk) begin
		unique case (dst_s2)
			svb_pkg::D_MX: mx_q <= svb_pkg::sat32(tot);
			svb_pkg::D_MY: my_q <= svb_pkg::sat32(tot);
			svb_pkg::D_PX: px_q <= svb_pkg::sat32(tot);
			svb_pkg::D_PY: py_q <= svb_pkg::sat32(tot);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (out_load && in_q.last_influence) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (dst_s2 == svb_pkg::D_AX) begin
			acc_x_q <= svb_pkg::sat48(tot);
		end else if (dst_s2 == svb_pkg::D_AY) begin
			acc_y_q <= svb_pkg::sat48(tot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load && in_q.last_influence) out_valid_q <= 1'b1;
		else if (vertex.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load && in_q.last_influence) begin
			out_q.vertex_x <= svb_pkg::sat32(60'(acc_x_q));
			out_q.vertex_y <= svb_pkg::sat32(-60'(acc_y_q));
		end
	end

	assign vertex.valid = out_valid_q;
	assign vertex.data  = out_q;

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		ready |-> dst_s2 == svb_pkg::D_NONE && ctrl_s1.kind == svb_pkg::K_NONE)
		else $error("accepting while products in flight");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && in_q.last_influence |=> vertex.valid)
		else $error("result beat not raised");

	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && in_q.last_influence |=> acc_x_q == '0 && acc_y_q == '0)
		else $error("accumulators not cleared after vertex");

endmodule

// ===== bench/skinned_vertex_blend_2d_core_tb.sv =====
`timescale 1ns / 1ps

module skinned_vertex_blend_2d_core_tb;
	import svb_pkg::*;

	localparam int      ONE          = 65536;
	localparam int      DRAIN_CYCLES = 40;
	localparam int      PHASE_ITEMS  = 210;
	localparam int      SAT_RUN      = 64;
	localparam longint  LIMIT        = 3000000;
	localparam int      MAX_PRINTS   = 40;

	localparam logic [16:0] W_TOP   = 17'h1FFFF;
	localparam logic [31:0] S32_TOP = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_BOT = 32'h8000_0000;
	localparam logic [23:0] S24_TOP = 24'h7F_FFFF;
	localparam logic [23:0] S24_BOT = 24'h80_0000;

	// indexes past the last register; writes there must be dropped
	localparam logic [2:0] R_SPARE_6 = 3'd6;
	localparam logic [2:0] R_SPARE_7 = 3'd7;

	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;
	localparam longint ACC_HI = 64'sd140737488355327;
	localparam longint ACC_LO = -64'sd140737488355328;

	typedef enum int {ST_TAME, ST_CORNER, ST_WILD, ST_MIXED} mix_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_idx;
	logic [31:0] wr_data;

	svb_chan_if #(.T(in_item_t))  infl_ch();
	svb_chan_if #(.T(out_item_t)) vert_ch();

	skinned_vertex_blend_2d_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_idx    (wr_idx),
		.wr_data   (wr_data),
		.influence (infl_ch),
		.vertex    (vert_ch)
	);

	in_item_t  feed[$];
	out_item_t expected_vertices[$];
	out_item_t want_v;
	int        sent;
	int        accepted;
	int        errors;
	longint    cycles;
	bit        steady;

	longint par_xx, par_xy, par_yx, par_yy, par_tx, par_ty;
	longint acc_x, acc_y;

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// round half up, then floor
	function automatic longint round_q(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint affine_pt(longint a, longint x, longint b, longint y, longint t);
		return clamp(round_q(a * x + b * y, FRAC_BITS) + t, S32_LO, S32_HI);
	endfunction

	function automatic void blend_influence(in_item_t it);
		longint w, bx, by, mx, my, px, py;
		out_item_t v;
		w  = longint'(it.weight);
		bx = longint'(signed'(it.bind_x));
		by = longint'(signed'(it.bind_y));
		mx = affine_pt(longint'(signed'(it.bone_xx)), bx, longint'(signed'(it.bone_yx)), by,
			longint'(signed'(it.bone_tx)));
		my = affine_pt(longint'(signed'(it.bone_xy)), bx, longint'(signed'(it.bone_yy)), by,
			longint'(signed'(it.bone_ty)));
		px = affine_pt(par_xx, mx, par_yx, my, par_tx);
		py = affine_pt(par_xy, mx, par_yy, my, par_ty);
		acc_x = clamp(acc_x + round_q(w * px, WEIGHT_BITS), ACC_LO, ACC_HI);
		acc_y = clamp(acc_y + round_q(w * py, WEIGHT_BITS), ACC_LO, ACC_HI);
		if (it.last_influence) begin
			v.vertex_x = 32'(clamp(acc_x, S32_LO, S32_HI));
			v.vertex_y = 32'(clamp(-acc_y, S32_LO, S32_HI));
			expected_vertices.push_back(v);
			acc_x = 0;
			acc_y = 0;
		end
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (errors < MAX_PRINTS)
			$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic int spread(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic logic [31:0] corner32();
		case ($urandom_range(4))
			0: return S32_TOP;
			1: return S32_BOT;
			2: return '0;
			3: return '1;
			default: return ONE;
		endcase
	endfunction

	function automatic logic [23:0] corner24();
		case ($urandom_range(4))
			0: return S24_TOP;
			1: return S24_BOT;
			2: return '0;
			3: return '1;
			default: return 24'(ONE);
		endcase
	endfunction

	function automatic in_item_t influence_of(longint w, longint bx, longint by,
		longint xx, longint xy, longint yx, longint yy,
		longint tx, longint ty, logic last);
		in_item_t t;
		t.weight         = 17'(w);
		t.bind_x         = 32'(bx);
		t.bind_y         = 32'(by);
		t.bone_xx        = 24'(xx);
		t.bone_xy        = 24'(xy);
		t.bone_yx        = 24'(yx);
		t.bone_yy        = 24'(yy);
		t.bone_tx        = 32'(tx);
		t.bone_ty        = 32'(ty);
		t.last_influence = last;
		return t;
	endfunction

	function automatic in_item_t random_influence(mix_t st, bit last);
		in_item_t t;
		mix_t s;
		s = st;
		if (s == ST_MIXED)
			s = mix_t'($urandom_range(2));
		case (s)
			ST_TAME: begin
				t = influence_of($urandom_range(ONE), spread(1 << 22), spread(1 << 22),
					spread(1 << 17), spread(1 << 17), spread(1 << 17), spread(1 << 17),
					spread(1 << 24), spread(1 << 24), last);
			end
			ST_CORNER: begin
				t = influence_of(ONE, corner32(), corner32(), corner24(), corner24(),
					corner24(), corner24(), corner32(), corner32(), last);
				case ($urandom_range(4))
					0: t.weight = '0;
					1: t.weight = W_TOP;
					2: t.weight = 17'd1;
					3: t.weight = 17'd32768;
					default: t.weight = 17'(ONE);
				endcase
			end
			default: begin
				t = influence_of($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, last);
			end
		endcase
		return t;
	endfunction

	task automatic offer(in_item_t it);
		feed.push_back(it);
		sent++;
	endtask

	task automatic queue_vertex(mix_t st);
		int n;
		n = $urandom_range(1, 4);
		if ($urandom_range(9) == 0)
			n = $urandom_range(5, 10);
		for (int i = 0; i < n; i++)
			offer(random_influence(st, i == n - 1));
	endtask

	task automatic run_vertices(int count);
		int start;
		int r;
		start = sent;
		while (sent - start < count) begin
			r = $urandom_range(99);
			if (r < 65)
				queue_vertex(ST_TAME);
			else if (r < 75)
				queue_vertex(ST_CORNER);
			else if (r < 85)
				queue_vertex(ST_WILD);
			else
				queue_vertex(ST_MIXED);
		end
	endtask

	task automatic drain();
		while (accepted != sent || expected_vertices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		wr_en   <= 1'b1;
		wr_idx  <= idx;
		wr_data <= val;
		case (idx)
			R_INV_XX: par_xx = longint'(signed'(val[23:0]));
			R_INV_XY: par_xy = longint'(signed'(val[23:0]));
			R_INV_YX: par_yx = longint'(signed'(val[23:0]));
			R_INV_YY: par_yy = longint'(signed'(val[23:0]));
			R_INV_TX: par_tx = longint'(signed'(val));
			R_INV_TY: par_ty = longint'(signed'(val));
			default: ;
		endcase
	endtask

	task automatic program_parent(logic [31:0] xx, logic [31:0] xy, logic [31:0] yx,
		logic [31:0] yy, logic [31:0] tx, logic [31:0] ty);
		write_reg(R_INV_XX, xx);
		write_reg(R_INV_XY, xy);
		write_reg(R_INV_YX, yx);
		write_reg(R_INV_YY, yy);
		write_reg(R_INV_TX, tx);
		write_reg(R_INV_TY, ty);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infl_ch.valid <= 1'b0;
			infl_ch.data  <= '0;
		end else if (!infl_ch.valid || infl_ch.ready) begin
			if (feed.size() != 0 && (steady || $urandom_range(99) >= 17)) begin
				infl_ch.valid <= 1'b1;
				infl_ch.data  <= feed.pop_front();
			end else begin
				infl_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vert_ch.ready <= 1'b0;
		else
			vert_ch.ready <= steady || $urandom_range(99) >= 17;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (vert_ch.valid && vert_ch.ready) begin
				if (expected_vertices.size() == 0) begin
					flag_mismatch("vertex beat, none due", vert_ch.data.vertex_x, '0);
				end else begin
					want_v = expected_vertices.pop_front();
					if (vert_ch.data.vertex_x !== want_v.vertex_x)
						flag_mismatch("vertex_x", vert_ch.data.vertex_x, want_v.vertex_x);
					if (vert_ch.data.vertex_y !== want_v.vertex_y)
						flag_mismatch("vertex_y", vert_ch.data.vertex_y, want_v.vertex_y);
				end
			end
			if (infl_ch.valid && infl_ch.ready) begin
				blend_influence(infl_ch.data);
				accepted <= accepted + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("skinned_vertex_blend_2d_core_tb: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		wr_en         = 1'b0;
		wr_idx        = '0;
		wr_data       = '0;
		infl_ch.valid = 1'b0;
		infl_ch.data  = '0;
		vert_ch.ready = 1'b0;
		steady        = 1'b0;
		sent          = 0;
		accepted      = 0;
		errors        = 0;
		cycles        = 0;
		par_xx        = ONE;
		par_xy        = 0;
		par_yx        = 0;
		par_yy        = ONE;
		par_tx        = 0;
		par_ty        = 0;
		acc_x         = 0;
		acc_y         = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset-value parent: plain cases
		offer(influence_of(ONE, ONE, 2 * ONE, ONE, 0, 0, ONE, 0, 0, 1'b1));
		offer(influence_of(0, 5 * ONE, -3 * ONE, ONE, 0, 0, ONE, ONE, ONE, 1'b1));
		offer(influence_of(32768, 4 * ONE, 0, ONE, 0, 0, ONE, 0, 0, 1'b0));
		offer(influence_of(32768, 0, 4 * ONE, 0, ONE, -ONE, 0, 0, 0, 1'b1));
		// bone-mapped point clipping both ways
		offer(influence_of(ONE, S32_TOP, 0, S24_TOP, 0, 0, 0, S32_TOP, 0, 1'b1));
		offer(influence_of(ONE, S32_BOT, S32_BOT, S24_TOP, S24_TOP, 0, 0, S32_BOT, S32_BOT,
			1'b1));
		// weight above one
		offer(influence_of(W_TOP, 7 * 32768, -5 * 16384, ONE, 0, 0, ONE, 0, 0, 1'b1));
		offer(influence_of(W_TOP, S32_BOT, S32_TOP, S24_BOT, S24_BOT, S24_BOT, S24_BOT,
			S32_TOP, S32_BOT, 1'b1));
		// sum past the output range
		offer(influence_of(ONE, 0, 0, 0, 0, 0, 0, S32_TOP, 0, 1'b0));
		offer(influence_of(ONE, 0, 0, 0, 0, 0, 0, S32_TOP, 0, 1'b1));
		// rounding at the half
		offer(influence_of(ONE, 32768, 0, 1, 0, 0, 0, 0, 0, 1'b0));
		offer(influence_of(ONE, -32768, 0, 1, 0, 0, 0, 0, 0, 1'b0));
		offer(influence_of(ONE, -32769, 0, 1, 0, 0, 0, 0, 0, 1'b0));
		offer(influence_of(1, 0, 0, 0, 0, 0, 0, 32768, -32768, 1'b1));
		// all clear, then all set
		offer(influence_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
		offer(influence_of(W_TOP, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1));
		drain();

		// one long vertex carries both sums far past the output range
		for (int i = 0; i < SAT_RUN; i++)
			offer(influence_of(W_TOP, 0, 0, 0, 0, 0, 0, S32_TOP, S32_BOT, i == SAT_RUN - 1));
		drain();

		program_parent(spread(1 << 17), spread(1 << 17), spread(1 << 17), spread(1 << 17),
			spread(1 << 24), spread(1 << 24));
		write_reg(R_SPARE_6, $urandom);
		write_reg(R_SPARE_7, $urandom);
		@(posedge clk);
		wr_en <= 1'b0;
		run_vertices(PHASE_ITEMS);
		drain();

		program_parent(ONE, 0, 0, ONE, 0, 0);
		steady <= 1'b1;
		run_vertices(PHASE_ITEMS);
		drain();
		steady <= 1'b0;

		program_parent({8'h00, S24_TOP}, {8'h00, S24_TOP}, {8'h00, S24_TOP},
			{8'h00, S24_TOP}, S32_TOP, S32_TOP);
		run_vertices(PHASE_ITEMS);
		drain();

		program_parent({8'hFF, S24_BOT}, {8'hFF, S24_BOT}, {8'hFF, S24_BOT},
			{8'hFF, S24_BOT}, S32_BOT, S32_BOT);
		run_vertices(PHASE_ITEMS);
		drain();

		// upper bits of the narrow registers carry junk
		program_parent($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		run_vertices(PHASE_ITEMS);
		drain();

		program_parent(spread(1 << 17), spread(1 << 17), spread(1 << 17), spread(1 << 17),
			spread(1 << 24), spread(1 << 24));
		run_vertices(PHASE_ITEMS);
		drain();

		if (errors == 0)
			$display("skinned_vertex_blend_2d_core_tb: PASS");
		else
			$display("skinned_vertex_blend_2d_core_tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
src/svb_pkg.sv
src/svb_chan_if.sv
src/svb_mul.sv
src/svb_seq.sv
src/skinned_vertex_blend_2d_core.sv
bench/skinned_vertex_blend_2d_core_tb.sv
